// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/sld_pkg.sv =====
// ---------------------------------------------------------------------------
// SLIP deframer package
// Byte codes, event kinds, widths and the result record of the deframer.
// ---------------------------------------------------------------------------
package sld_pkg;

    localparam int MAX_BUFFER_BYTES = 1024;
    localparam int CFG_W            = 11;
    localparam int CNT_W            = $clog2(MAX_BUFFER_BYTES);
    localparam int LEN_W            = 10;

    localparam logic [7:0] FLOW_BYTE    = 8'h0D;
    localparam logic [7:0] END_BYTE     = 8'hC0;
    localparam logic [7:0] ESC_BYTE     = 8'hDB;
    localparam logic [7:0] END_ESCAPED  = 8'hDC;
    localparam logic [7:0] ESC_ESCAPED  = 8'hDD;
    localparam logic [7:0] FLOW_ESCAPED = 8'hDE;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_DATA     = 2'd1,
        EV_END      = 2'd2,
        EV_OVERFLOW = 2'd3
    } event_kind_t;

    typedef struct packed {
        event_kind_t      kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] length;
    } sld_result_t;

    // Highest count that may be stored: buffer size saturated, minus one.
    function automatic logic [CNT_W-1:0] store_limit(input logic [CFG_W-1:0] size);
        logic [CFG_W-1:0] sat;
        sat = (size > CFG_W'(MAX_BUFFER_BYTES)) ? CFG_W'(MAX_BUFFER_BYTES) : size;
        if (sat == '0)
            return '0;
        return CNT_W'(sat - CFG_W'(1));
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            END_ESCAPED:  r = END_BYTE;
            ESC_ESCAPED:  r = ESC_BYTE;
            FLOW_ESCAPED: r = FLOW_BYTE;
            default:      r = b;
        endcase
        return r;
    endfunction

endpackage

// ===== src/sld_rx_if.sv =====
// ---------------------------------------------------------------------------
// Raw byte channel
// Valid/ready channel carrying one received serial byte per beat.
// ---------------------------------------------------------------------------
interface sld_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== src/sld_ev_if.sv =====
// ---------------------------------------------------------------------------
// Deframer event channel
// Valid/ready channel carrying one decoded event per beat.
// ---------------------------------------------------------------------------
interface sld_ev_if;
    logic                             valid;
    logic                             ready;
    sld_pkg::event_kind_t             event_kind;
    logic [7:0]                       data_byte;
    logic [sld_pkg::LEN_W-1:0]        frame_length;

    modport source (output valid, output event_kind, output data_byte,
                    output frame_length, input ready);
    modport sink   (input valid, input event_kind, input data_byte,
                    input frame_length, output ready);
endinterface

// ===== src/sld_core.sv =====
// ---------------------------------------------------------------------------
// SLIP deframer core
// Escape and frame-count state with the per-byte decode logic.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sld_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [7:0]                  rx_byte,
    input  logic [sld_pkg::CNT_W-1:0]   limit,
    output sld_pkg::sld_result_t        result
);

    logic                        escape_reg;
    logic                        escape_next;
    logic [sld_pkg::CNT_W-1:0]   count_reg;
    logic [sld_pkg::CNT_W-1:0]   count_next;

    always_comb
    begin
        result.kind   = sld_pkg::EV_NONE;
        result.data   = '0;
        result.length = '0;
        escape_next   = escape_reg;
        count_next    = count_reg;
        if (count_reg >= limit)
        begin
            // buffer full: discard the frame whatever the byte is
            result.kind = sld_pkg::EV_OVERFLOW;
            count_next  = '0;
            escape_next = 1'b0;
        end
        else if (rx_byte == sld_pkg::FLOW_BYTE)
        begin
            // drop flow byte, keep any pending escape
        end
        else if (escape_reg)
        begin
            escape_next = 1'b0;
            result.kind = sld_pkg::EV_DATA;
            result.data = sld_pkg::unescape(rx_byte);
            count_next  = count_reg + sld_pkg::CNT_W'(1);
        end
        else if (rx_byte == sld_pkg::ESC_BYTE)
        begin
            escape_next = 1'b1;
        end
        else if (rx_byte == sld_pkg::END_BYTE)
        begin
            result.kind   = sld_pkg::EV_END;
            result.length = sld_pkg::LEN_W'(count_reg);
            count_next    = '0;
        end
        else
        begin
            result.kind = sld_pkg::EV_DATA;
            result.data = rx_byte;
            count_next  = count_reg + sld_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg <= 1'b0;
            count_reg  <= '0;
        end
        else if (step)
        begin
            escape_reg <= escape_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_NEXT(a_overflow_clears, clk, rst_n,
        step && result.kind == sld_pkg::EV_OVERFLOW, count_reg == '0 && !escape_reg)
    `ASSERT_NEXT(a_data_counts, clk, rst_n,
        step && result.kind == sld_pkg::EV_DATA,
        count_reg == $past(count_reg) + sld_pkg::CNT_W'(1))
    `ASSERT_IMPLY(a_end_below_limit, clk, rst_n,
        result.kind == sld_pkg::EV_END, sld_pkg::CNT_W'(result.length) < limit)

endmodule

// ===== src/slip_deframer_with_flow_escape.sv =====
// ---------------------------------------------------------------------------
// SLIP deframer with flow escape
// Strips SLIP framing and flow bytes from a received byte stream.
// ---------------------------------------------------------------------------
// Usage:
//   rx  : one raw serial byte per beat (valid/ready).
//   ev  : exactly one event per rx beat: nothing, data byte, frame end with
//         its payload length, or overflow. Events leave in rx order.
//   cfg : cfg_wr_en/cfg_wr_data write the buffer size (max_frame_bytes);
//         write only while no beat is in flight.
// An accepted rx beat goes through one input register, then the decode into
// the output register, and leaves as its ev beat. Throughput is one byte per
// cycle while ev does not stall, set by the escape/count update in the core.
// Reset clears the escape flag, the frame count and both stage valids, and
// sets the buffer size to 1024. When ev stalls, the output register holds
// its event, the input register takes one more byte, and rx.ready then
// drops until ev.ready returns.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slip_deframer_with_flow_escape (
    input  logic                          clk,
    input  logic                          rst_n,
    sld_rx_if.sink                        rx,
    sld_ev_if.source                      ev,
    input  logic                          cfg_wr_en,
    input  logic [sld_pkg::CFG_W-1:0]     cfg_wr_data
);

    logic                        s1_valid_reg;
    logic [7:0]                  s1_byte_reg;
    logic                        out_valid_reg;
    sld_pkg::sld_result_t        out_res_reg;
    logic [sld_pkg::CNT_W-1:0]   limit_reg;
    logic                        advance;
    sld_pkg::sld_result_t        core_res;

    assign advance  = s1_valid_reg && (!out_valid_reg || ev.ready);
    assign rx.ready = !s1_valid_reg || advance;

    sld_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (s1_byte_reg),
        .limit   (limit_reg),
        .result  (core_res)
    );

    // store the limit already saturated and reduced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= sld_pkg::store_limit(sld_pkg::CFG_RESET);
        else if (cfg_wr_en)
            limit_reg <= sld_pkg::store_limit(cfg_wr_data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx.valid && rx.ready)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (ev.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            s1_byte_reg <= rx.rx_byte;
        if (advance)
            out_res_reg <= core_res;
    end

    assign ev.valid        = out_valid_reg;
    assign ev.event_kind   = out_res_reg.kind;
    assign ev.data_byte    = out_res_reg.data;
    assign ev.frame_length = out_res_reg.length;

    `ASSERT_NEXT(a_advance_fills_out, clk, rst_n, advance, out_valid_reg)
    `ASSERT_IMPLY(a_no_take_when_full, clk, rst_n,
        s1_valid_reg && out_valid_reg && !ev.ready, !rx.ready)
    `ASSERT_NEXT(a_hold_when_stalled, clk, rst_n,
        ev.valid && !ev.ready, ev.valid && $stable(out_res_reg))

endmodule
